// ===== sv/dfg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfg_pkg
// Shared widths, codes and the cell payload type of the defocus estimator.
// ----------------------------------------------------------------------------
package dfg_pkg;

  localparam int GRAD_BITS  = 20;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int SIGMA_W    = 10;
  localparam int MAXB_W     = 8;
  localparam int CFG_DATA_W = (SIGMA_W > MAXB_W) ? SIGMA_W : MAXB_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REBLUR_SIGMA = 1'b0,
    CFG_MAX_BLUR     = 1'b1
  } cfg_reg_e;

  localparam logic [SIGMA_W-1:0] SIGMA_RST = SIGMA_W'(256);
  localparam logic [MAXB_W-1:0]  MAXB_RST  = MAXB_W'(5);

  // output level
  localparam int LEVEL_W     = 8;
  localparam int LEVEL_IDX_W = $clog2(LEVEL_W);
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  // 255^2 folded into the right-hand side
  localparam int SCALE_K_W  = 16;
  localparam logic [SCALE_K_W-1:0] SCALE_K = SCALE_K_W'(65025);
  localparam int SIGSQ_W    = 2 * SIGMA_W;
  localparam int SCALE_W    = SIGSQ_W + SCALE_K_W;
  localparam int SCALE_LO_W = SCALE_W / 2;
  localparam int SCALE_HI_W = SCALE_W - SCALE_LO_W;
  localparam int MSQ_W      = 2 * MAXB_W;

  // denominator (g1-g2)(g1+g2), numerator (3g2-2g1)(3g2+2g1)
  localparam int DEN_W      = 2 * GRAD_BITS + 1;
  localparam int DEN_LO_W   = DEN_W / 2;
  localparam int DEN_HI_W   = DEN_W - DEN_LO_W;
  localparam int NUM_W      = 2 * GRAD_BITS + 4;
  localparam int NUM_LO_W   = NUM_W / 2;
  localparam int NUM_HI_W   = NUM_W - NUM_LO_W;

  // Q2.8 squared (16) and the factor 4 of 1.5^2 = 9/4 (2)
  localparam int RHS_SHIFT  = 18;
  localparam int RHS_W      = NUM_W + SCALE_W;
  localparam int RS_W       = RHS_W - RHS_SHIFT;

  // running terms of the bit search: v = M^2*D, u = k*v, s = k^2*v
  localparam int V_W        = DEN_W + MSQ_W;
  localparam int U_W        = V_W + LEVEL_W;
  localparam int S_W        = V_W + 2 * LEVEL_W + 2;

  typedef struct packed {
    logic               search;
    logic [LEVEL_W-1:0] k;
    logic [S_W-1:0]     s;
    logic [U_W-1:0]     u;
    logic [V_W-1:0]     v;
    logic [RS_W-1:0]    rs;
  } dfg_cell_t;

endpackage
`default_nettype wire

// ===== sv/dfg_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfg_front
// Classifies each pixel and forms the two sides of the sigma inequality.
// ----------------------------------------------------------------------------
module dfg_front import dfg_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [GRAD_BITS-1:0] grad_fine_i,
  input  wire logic [GRAD_BITS-1:0] grad_coarse_i,
  input  wire logic                 edge_flag_i,
  input  wire logic [SCALE_W-1:0]   scale_i,
  input  wire logic [MSQ_W-1:0]     max_sq_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output dfg_cell_t                 out_data_o
);

  localparam int PW = GRAD_BITS + 7;
  localparam int TW = GRAD_BITS + 3;

  logic                 rdy1, rdy2, rdy3, rdy4;

  // stage 1: captured request
  logic                 vld1_q;
  logic [GRAD_BITS-1:0] a_q, b_q;
  logic                 edge_q;

  // stage 2: classification and the two quadratic terms
  logic                 vld2_q, srch2_q;
  logic [LEVEL_W-1:0]   k2_q;
  logic [DEN_W-1:0]     den2_q;
  logic [NUM_W-1:0]     num2_q;

  logic [PW-1:0]        a100, b101;
  logic [TW-1:0]        a2, b3, n_sub, n_add;
  logic [GRAD_BITS:0]   g_sum;
  logic [GRAD_BITS-1:0] g_diff;
  logic                 is_zero, is_sat;
  logic                 srch2_d;
  logic [LEVEL_W-1:0]   k2_d;
  logic [DEN_W-1:0]     den2_d;
  logic [NUM_W-1:0]     num2_d;

  // stage 3: partial products
  logic                              vld3_q, srch3_q;
  logic [LEVEL_W-1:0]                k3_q;
  logic [MSQ_W+DEN_LO_W-1:0]         vlo3_q;
  logic [MSQ_W+DEN_HI_W-1:0]         vhi3_q;
  logic [SCALE_LO_W+NUM_LO_W-1:0]    pll3_q;
  logic [SCALE_LO_W+NUM_HI_W-1:0]    plh3_q;
  logic [SCALE_HI_W+NUM_LO_W-1:0]    phl3_q;
  logic [SCALE_HI_W+NUM_HI_W-1:0]    phh3_q;

  // stage 4: cell payload
  logic                 vld4_q;
  dfg_cell_t            out_q, out_d;
  logic [RHS_W-1:0]     rhs;

  assign rdy4       = !vld4_q || out_ready_i;
  assign rdy3       = !vld3_q || rdy4;
  assign rdy2       = !vld2_q || rdy3;
  assign rdy1       = !vld1_q || rdy2;
  assign in_ready_o = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
      vld3_q <= 1'b0;
      vld4_q <= 1'b0;
    end else begin
      if (rdy1) vld1_q <= in_valid_i;
      if (rdy2) vld2_q <= vld1_q;
      if (rdy3) vld3_q <= vld2_q;
      if (rdy4) vld4_q <= vld3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_valid_i) begin
      a_q    <= grad_fine_i;
      b_q    <= grad_coarse_i;
      edge_q <= edge_flag_i;
    end
  end

  always_comb begin
    a100    = PW'(a_q) * PW'(100);
    b101    = PW'(b_q) * PW'(101);
    a2      = TW'(a_q) << 1;
    b3      = (TW'(b_q) << 1) + TW'(b_q);
    n_sub   = b3 - a2;
    n_add   = b3 + a2;
    g_diff  = a_q - b_q;
    g_sum   = (GRAD_BITS + 1)'(a_q) + (GRAD_BITS + 1)'(b_q);
    is_zero = !edge_q || (b_q == '0) || (a100 <= b101);
    is_sat  = (a2 >= b3);
    srch2_d = !is_zero && !is_sat;
    k2_d    = (!is_zero && is_sat) ? LEVEL_MAX : '0;
    den2_d  = DEN_W'(g_diff) * DEN_W'(g_sum);
    num2_d  = NUM_W'(n_sub) * NUM_W'(n_add);
  end

  always_ff @(posedge clk_i) begin
    if (rdy2 && vld1_q) begin
      srch2_q <= srch2_d;
      k2_q    <= k2_d;
      den2_q  <= den2_d;
      num2_q  <= num2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && vld2_q) begin
      srch3_q <= srch2_q;
      k3_q    <= k2_q;
      vlo3_q  <= (MSQ_W + DEN_LO_W)'(max_sq_i) * (MSQ_W + DEN_LO_W)'(den2_q[DEN_LO_W-1:0]);
      vhi3_q  <= (MSQ_W + DEN_HI_W)'(max_sq_i) * (MSQ_W + DEN_HI_W)'(den2_q[DEN_W-1:DEN_LO_W]);
      pll3_q  <= (SCALE_LO_W + NUM_LO_W)'(scale_i[SCALE_LO_W-1:0])
               * (SCALE_LO_W + NUM_LO_W)'(num2_q[NUM_LO_W-1:0]);
      plh3_q  <= (SCALE_LO_W + NUM_HI_W)'(scale_i[SCALE_LO_W-1:0])
               * (SCALE_LO_W + NUM_HI_W)'(num2_q[NUM_W-1:NUM_LO_W]);
      phl3_q  <= (SCALE_HI_W + NUM_LO_W)'(scale_i[SCALE_W-1:SCALE_LO_W])
               * (SCALE_HI_W + NUM_LO_W)'(num2_q[NUM_LO_W-1:0]);
      phh3_q  <= (SCALE_HI_W + NUM_HI_W)'(scale_i[SCALE_W-1:SCALE_LO_W])
               * (SCALE_HI_W + NUM_HI_W)'(num2_q[NUM_W-1:NUM_LO_W]);
    end
  end

  always_comb begin
    rhs = RHS_W'(pll3_q)
        + (RHS_W'(plh3_q) << NUM_LO_W)
        + (RHS_W'(phl3_q) << SCALE_LO_W)
        + (RHS_W'(phh3_q) << (SCALE_LO_W + NUM_LO_W));
    out_d.search = srch3_q;
    out_d.k      = k3_q;
    out_d.s      = '0;
    out_d.u      = '0;
    out_d.v      = V_W'(vlo3_q) + (V_W'(vhi3_q) << DEN_LO_W);
    // exact: s*2^18 <= rhs  <=>  s <= floor(rhs / 2^18)
    out_d.rs     = rhs[RHS_W-1:RHS_SHIFT];
  end

  always_ff @(posedge clk_i) begin
    if (rdy4 && vld3_q) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld4_q;
  assign out_data_o  = out_q;

endmodule
`default_nettype wire

// ===== sv/dfg_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dfg_cell
// One bit of the level search: tries k | 2^j and keeps it if it still fits.
// ----------------------------------------------------------------------------
module dfg_cell import dfg_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [LEVEL_IDX_W-1:0] bit_idx_i,
  input  wire logic                   in_valid_i,
  output logic                        in_ready_o,
  input  wire dfg_cell_t              in_data_i,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output dfg_cell_t                   out_data_o
);

  logic                 vld_q;
  dfg_cell_t            data_q, data_d;
  logic [LEVEL_IDX_W:0] sh_u;
  logic [S_W-1:0]       trial;
  logic [U_W-1:0]       u_next;
  logic                 fits;

  assign in_ready_o = !vld_q || out_ready_i;

  // (k+2^j)^2 v = k^2 v + 2^(j+1) k v + 2^(2j) v
  always_comb begin
    sh_u   = {1'b0, bit_idx_i} + (LEVEL_IDX_W + 1)'(1);
    trial  = in_data_i.s
           + (S_W'(in_data_i.u) << sh_u)
           + (S_W'(in_data_i.v) << {bit_idx_i, 1'b0});
    u_next = in_data_i.u + (U_W'(in_data_i.v) << bit_idx_i);
    fits   = (trial <= S_W'(in_data_i.rs));
    data_d = in_data_i;
    if (in_data_i.search && fits) begin
      data_d.s = trial;
      data_d.u = u_next;
      data_d.k = in_data_i.k | (LEVEL_W'(1) << bit_idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (in_ready_o) begin
      vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_data_o  = data_q;

endmodule
`default_nettype wire

// ===== sv/defocus_from_gradient_ratio.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// defocus_from_gradient_ratio
// Blur level of an edge pixel from the ratio of two reblurred gradients.
// ----------------------------------------------------------------------------
// Takes one pixel request per clock while the output is not stalled and returns
// one blur level per pixel, in order, through four front stages (capture,
// classification with the two quadratic terms, partial products, final sums)
// followed by a chain of eight search cells, each settling one bit of the
// level from the most significant down. Every stage holds its own request, so
// stalls at the output only fill empty stages and the input keeps taking
// requests while any stage is free. Non-edge pixels and ratios not above 1.01
// give 0; ratios at or above 1.5 give 255. The user must write configuration
// via the plain write port only while the block is idle; it is not enforced.
// ----------------------------------------------------------------------------
module defocus_from_gradient_ratio import dfg_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [GRAD_BITS-1:0]  grad_fine_i,
  input  wire logic [GRAD_BITS-1:0]  grad_coarse_i,
  input  wire logic                  edge_flag_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [LEVEL_W-1:0]         blur_level_o
);

  logic [SIGMA_W-1:0] sigma_q;
  logic [MAXB_W-1:0]  max_blur_q;
  logic [SIGSQ_W-1:0] sig_sq_q;
  logic [SCALE_W-1:0] scale_q;
  logic [MSQ_W-1:0]   max_sq_q;

  dfg_cell_t          chain_data [LEVEL_W+1];
  logic [LEVEL_W:0]   chain_vld;
  logic [LEVEL_W:0]   chain_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sigma_q    <= SIGMA_RST;
      max_blur_q <= MAXB_RST;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        CFG_REBLUR_SIGMA: sigma_q    <= cfg_wdata_i[SIGMA_W-1:0];
        CFG_MAX_BLUR:     max_blur_q <= cfg_wdata_i[MAXB_W-1:0];
        default: ;
      endcase
    end
  end

  // derived factors, registered: sigma squared, then scaled by 255^2; max_blur squared
  always_ff @(posedge clk_i) begin
    sig_sq_q <= SIGSQ_W'(sigma_q) * SIGSQ_W'(sigma_q);
    scale_q  <= SCALE_W'(sig_sq_q) * SCALE_W'(SCALE_K);
    max_sq_q <= MSQ_W'(max_blur_q) * MSQ_W'(max_blur_q);
  end

  dfg_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .grad_fine_i   (grad_fine_i),
    .grad_coarse_i (grad_coarse_i),
    .edge_flag_i   (edge_flag_i),
    .scale_i       (scale_q),
    .max_sq_i      (max_sq_q),
    .out_valid_o   (chain_vld[0]),
    .out_ready_i   (chain_rdy[0]),
    .out_data_o    (chain_data[0])
  );

  for (genvar g = 0; g < LEVEL_W; g++) begin : g_cell
    dfg_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .bit_idx_i   (LEVEL_IDX_W'(LEVEL_W - 1 - g)),
      .in_valid_i  (chain_vld[g]),
      .in_ready_o  (chain_rdy[g]),
      .in_data_i   (chain_data[g]),
      .out_valid_o (chain_vld[g+1]),
      .out_ready_i (chain_rdy[g+1]),
      .out_data_o  (chain_data[g+1])
    );
  end

  assign chain_rdy[LEVEL_W] = out_ready_i;
  assign out_valid_o        = chain_vld[LEVEL_W];
  assign blur_level_o       = chain_data[LEVEL_W].k;

endmodule
`default_nettype wire

// ===== bench/defocus_from_gradient_ratio_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// defocus_from_gradient_ratio_tb
// Self-checking bench for the gradient-ratio defocus estimator.
// ----------------------------------------------------------------------------
// Pixel requests go in through a valid/ready channel with random gaps, and
// blur levels come out through a valid/ready channel with random stalls. A
// scoreboard predicts every level with exact wide-integer arithmetic and
// checks results in order. Boundary ratios, zero magnitudes and the
// zero register values are hit first, then random pixels under
// several register settings, mostly in the ratio band that reaches the search.
// ----------------------------------------------------------------------------
module defocus_from_gradient_ratio_tb;
  import dfg_pkg::*;

  localparam int          PHASES      = 8;
  localparam int          PHASE_ITEMS = 135;
  localparam int          TAIL_CYCLES = 16;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic [GRAD_BITS-1:0] fine;
    logic [GRAD_BITS-1:0] coarse;
    logic                 edge_on;
    logic [LEVEL_W-1:0]   level;
  } pixel_level_t;

  class blur_scoreboard;
    logic [SIGMA_W-1:0] sigma_q48;
    logic [MAXB_W-1:0]  max_blur;
    pixel_level_t       pending_levels[$];
    int unsigned        mismatches;

    function new();
      sigma_q48  = SIGMA_RST;
      max_blur   = MAXB_RST;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_REBLUR_SIGMA: sigma_q48 = val[SIGMA_W-1:0];
        CFG_MAX_BLUR:     max_blur  = val[MAXB_W-1:0];
        default: ;
      endcase
    endfunction

    // largest k with (k*max_blur)^2 * den <= num, all in exact integers
    function logic [LEVEL_W-1:0] blur_level_of(logic [GRAD_BITS-1:0] fine,
                                               logic [GRAD_BITS-1:0] coarse,
                                               logic edge_on);
      logic [127:0]       g1, g2, den, num, km;
      logic [LEVEL_W-1:0] lvl;
      int                 k;
      g1 = 128'(fine);
      g2 = 128'(coarse);
      if (!edge_on || g2 == 0 || 100 * g1 <= 101 * g2) return '0;
      if (2 * g1 >= 3 * g2) return LEVEL_MAX;
      den = ((g1 - g2) * (g1 + g2)) << RHS_SHIFT;
      num = (3 * g2 - 2 * g1) * (3 * g2 + 2 * g1) * 128'(SCALE_K)
            * 128'(sigma_q48) * 128'(sigma_q48);
      lvl = '0;
      for (k = 1; k <= 255; k++) begin
        km = 128'(k) * 128'(max_blur);
        if (den * km * km <= num) begin
          lvl = LEVEL_W'(k);
        end else begin
          break;
        end
      end
      return lvl;
    endfunction

    function void note_pixel(logic [GRAD_BITS-1:0] fine, logic [GRAD_BITS-1:0] coarse,
                             logic edge_on);
      pixel_level_t px;
      px.fine    = fine;
      px.coarse  = coarse;
      px.edge_on = edge_on;
      px.level   = blur_level_of(fine, coarse, edge_on);
      pending_levels.push_back(px);
    endfunction

    function void check_level(logic [LEVEL_W-1:0] actual);
      pixel_level_t px;
      if (pending_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected blur level %0d with no pixel pending", actual);
        return;
      end
      px = pending_levels.pop_front();
      if (actual !== px.level) begin
        mismatches++;
        if (mismatches <= 10)
          $display("blur level mismatch: fine=%0d coarse=%0d edge=%0d expected %0d, got %0d",
                   px.fine, px.coarse, px.edge_on, px.level, actual);
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic [GRAD_BITS-1:0]  grad_fine_i;
  logic [GRAD_BITS-1:0]  grad_coarse_i;
  logic                  edge_flag_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic [LEVEL_W-1:0]    blur_level_o;

  blur_scoreboard sb;
  bit             gap_on;
  int unsigned    cycles;

  defocus_from_gradient_ratio u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .grad_fine_i  (grad_fine_i),
    .grad_coarse_i(grad_coarse_i),
    .edge_flag_i  (edge_flag_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .blur_level_o (blur_level_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[defocus_from_gradient_ratio] ERROR");
      $finish;
    end
  end

  // accepted requests feed the predictor, accepted levels are checked
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o)
      sb.note_pixel(grad_fine_i, grad_coarse_i, edge_flag_i);
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_level(blur_level_o);
  end

  // output side back-pressure
  initial begin : ready_gen
    int unsigned hold;
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (gap_on && $urandom_range(0, 4) == 0) begin
        hold = $urandom_range(1, 9);
        out_ready_i <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    sb.set_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input logic [GRAD_BITS-1:0] fine,
                            input logic [GRAD_BITS-1:0] coarse, input logic edge_on);
    int unsigned gap;
    if (gap_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 9);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    grad_fine_i   <= fine;
    grad_coarse_i <= coarse;
    edge_flag_i   <= edge_on;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_levels();
    in_valid_i <= 1'b0;
    while (sb.pending_levels.size() != 0) @(posedge clk_i);
  endtask

  // mostly ratios inside (1.01, 1.5) so the search runs; some at the two
  // thresholds, some fully random noise
  function automatic void pick_pixel(output logic [GRAD_BITS-1:0] fine,
                                     output logic [GRAD_BITS-1:0] coarse,
                                     output logic edge_on);
    longint unsigned c64, f64, top;
    int unsigned     sel;
    top     = (64'd1 << GRAD_BITS) - 1;
    sel     = $urandom_range(0, 9);
    edge_on = ($urandom_range(0, 7) != 0);
    c64     = 64'($urandom) >> (32 - GRAD_BITS + $urandom_range(0, GRAD_BITS));
    if (sel < 7) begin
      f64 = c64 + c64 * $urandom_range(90, 5200) / 10000 + $urandom_range(0, 1);
    end else if (sel == 7) begin
      f64 = ($urandom_range(0, 1) ? (c64 * 101) / 100 : (c64 * 3) / 2)
            + $urandom_range(0, 1);
    end else begin
      f64 = 64'($urandom) & top;
      c64 = 64'($urandom) & top;
    end
    if (f64 > top) f64 = top;
    fine   = f64[GRAD_BITS-1:0];
    coarse = c64[GRAD_BITS-1:0];
  endfunction

  initial begin : stimulus
    logic [GRAD_BITS-1:0]  f, c;
    logic                  e;
    logic [CFG_DATA_W-1:0] sig, mb;
    int                    p, i;

    sb = new();
    gap_on = 1'b0;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= CFG_REBLUR_SIGMA;
    cfg_wdata_i   <= '0;
    in_valid_i    <= 1'b0;
    grad_fine_i   <= '0;
    grad_coarse_i <= '0;
    edge_flag_i   <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: thresholds, zero magnitudes, full-scale values
    gap_on = 1'b1;
    send_pixel(20'd1200, 20'd1000, 1'b0);
    send_pixel(20'd0, 20'd0, 1'b1);
    send_pixel(20'd5, 20'd0, 1'b1);
    send_pixel(20'd0, 20'd1000, 1'b1);
    send_pixel(20'd101, 20'd100, 1'b1);
    send_pixel(20'd102, 20'd100, 1'b1);
    send_pixel(20'd150, 20'd100, 1'b1);
    send_pixel(20'd149, 20'd100, 1'b1);
    send_pixel(20'd1048575, 20'd1048575, 1'b1);
    send_pixel(20'd1048575, 20'd0, 1'b1);
    send_pixel(20'd1048575, 20'd699050, 1'b1);
    send_pixel(20'd1048575, 20'd699051, 1'b1);
    send_pixel(20'd1048575, 20'd1038193, 1'b1);
    send_pixel(20'd1048575, 20'd1038194, 1'b1);
    send_pixel(20'd1048575, 20'd1048575, 1'b0);
    send_pixel(20'd1200, 20'd1000, 1'b1);
    drain_levels();

    // zero sigma, zero max_blur, both zero
    write_reg(CFG_REBLUR_SIGMA, '0);
    send_pixel(20'd1200, 20'd1000, 1'b1);
    send_pixel(20'd1480, 20'd1000, 1'b1);
    drain_levels();
    write_reg(CFG_REBLUR_SIGMA, CFG_DATA_W'(256));
    write_reg(CFG_MAX_BLUR, '0);
    send_pixel(20'd1015, 20'd1000, 1'b1);
    send_pixel(20'd1200, 20'd1000, 1'b1);
    drain_levels();
    write_reg(CFG_REBLUR_SIGMA, '0);
    send_pixel(20'd1200, 20'd1000, 1'b1);
    send_pixel(20'd1015, 20'd1000, 1'b1);
    drain_levels();

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin sig = CFG_DATA_W'(1023); mb = CFG_DATA_W'(255); end
        1: begin sig = CFG_DATA_W'(128);  mb = CFG_DATA_W'(1);   end
        2: begin sig = CFG_DATA_W'(128);  mb = CFG_DATA_W'(255); end
        3: begin sig = CFG_DATA_W'(1023); mb = CFG_DATA_W'(1);   end
        default: begin
          sig = CFG_DATA_W'($urandom_range(128, 1023));
          mb  = CFG_DATA_W'($urandom_range(1, 255));
        end
      endcase
      write_reg(CFG_REBLUR_SIGMA, sig);
      write_reg(CFG_MAX_BLUR, mb);
      gap_on = (p < PHASES - 2) && (p != 2);
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 4 && i == PHASE_ITEMS / 2) drain_levels();  // let the pipe empty out
        pick_pixel(f, c, e);
        send_pixel(f, c, e);
      end
      drain_levels();
    end

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_levels.size() == 0) begin
      $display("[defocus_from_gradient_ratio] OK");
    end else begin
      $display("[defocus_from_gradient_ratio] ERROR");
    end
    $finish;
  end

endmodule
